// File: rtl/wsab_pkg.sv
// Package for the weighted sample accumulation buffer.
// Holds store geometry, field widths, action and status codes and the queue entry type.
// No dependencies.
package wsab_pkg;

	localparam int MaxWidth  = 128;
	localparam int MaxHeight = 128;
	localparam int XW        = 7;
	localparam int YW        = 7;
	localparam int AW        = XW + YW;
	localparam int Depth     = MaxWidth * MaxHeight;
	localparam int SumW      = 48;
	localparam int WSumW     = 32;
	localparam int SampW     = 25;
	localparam int WtW       = 16;
	localparam int QDepth    = 2;

	localparam logic [1:0] ActAdd     = 2'd0;
	localparam logic [1:0] ActResolve = 2'd1;
	localparam logic [1:0] ActClear   = 2'd2;

	localparam logic [1:0] StOk      = 2'd0;
	localparam logic [1:0] StRange   = 2'd1;
	localparam logic [1:0] StInvalid = 2'd2;
	localparam logic [1:0] StSat     = 2'd3;

	// Operation codes after classification in the front part.
	typedef enum logic [1:0] {
		OP_NONE    = 2'd0,
		OP_ADD     = 2'd1,
		OP_RESOLVE = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	typedef struct packed {
		op_t                     op;
		logic [AW-1:0]           addr;
		logic signed [SampW-1:0] r;
		logic signed [SampW-1:0] g;
		logic signed [SampW-1:0] b;
		logic signed [WtW-1:0]   w;
		logic                    bad;
		logic [1:0]              status;
	} cmd_t;

endpackage

// File: rtl/wsab_front.sv
// Front part: accepts requests, checks coordinates, applies the vertical flip.
// Depends on wsab_pkg.
module wsab_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              valid,
	output logic                              ready,
	input  logic [1:0]                        action,
	input  logic [wsab_pkg::XW-1:0]           pos_x,
	input  logic [wsab_pkg::YW-1:0]           pos_y,
	input  logic signed [wsab_pkg::SampW-1:0] sample_red,
	input  logic signed [wsab_pkg::SampW-1:0] sample_green,
	input  logic signed [wsab_pkg::SampW-1:0] sample_blue,
	input  logic signed [wsab_pkg::WtW-1:0]   sample_weight,
	input  logic                              sample_bad,
	input  logic [7:0]                        frame_width,
	input  logic [7:0]                        frame_height,
	output logic                              cmd_valid,
	input  logic                              cmd_ready,
	output wsab_pkg::cmd_t                    cmd
);
	logic [wsab_pkg::QDepth-1:0] vld_q;
	wsab_pkg::cmd_t               ent_q [wsab_pkg::QDepth];
	logic                         wr_q, rd_q;
	logic [8:0]                   w_eff, h_eff;
	logic                         in_range;
	logic [wsab_pkg::YW-1:0]      fy;
	logic [8:0]                   fy_w;
	wsab_pkg::cmd_t               c;

	assign w_eff = (frame_width > 8'(wsab_pkg::MaxWidth)) ? 9'(wsab_pkg::MaxWidth)
		: {1'b0, frame_width};
	assign h_eff = (frame_height > 8'(wsab_pkg::MaxHeight)) ? 9'(wsab_pkg::MaxHeight)
		: {1'b0, frame_height};
	assign in_range = ({2'b0, pos_x} < w_eff) && ({2'b0, pos_y} < h_eff);
	assign fy_w = h_eff - 9'd1 - {2'b0, pos_y};
	assign fy = fy_w[wsab_pkg::YW-1:0];

	always_comb begin
		c = '0;
		c.r = sample_red;
		c.g = sample_green;
		c.b = sample_blue;
		c.w = sample_weight;
		c.bad = sample_bad;
		c.addr = {pos_y, pos_x};
		c.status = wsab_pkg::StOk;
		case (action)
			wsab_pkg::ActAdd: begin
				c.op = in_range ? wsab_pkg::OP_ADD : wsab_pkg::OP_NONE;
				if (!in_range) c.status = wsab_pkg::StRange;
			end
			wsab_pkg::ActResolve: begin
				c.op = in_range ? wsab_pkg::OP_RESOLVE : wsab_pkg::OP_NONE;
				c.addr = {fy, pos_x};
				if (!in_range) c.status = wsab_pkg::StRange;
			end
			wsab_pkg::ActClear: c.op = wsab_pkg::OP_CLEAR;
			default: c.op = wsab_pkg::OP_NONE;
		endcase
	end

	assign ready = !vld_q[wr_q];
	assign cmd_valid = vld_q[rd_q];
	assign cmd = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (valid && ready) ent_q[wr_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			wr_q <= 1'b0;
			rd_q <= 1'b0;
		end else begin
			if (valid && ready) begin
				vld_q[wr_q] <= 1'b1;
				wr_q <= !wr_q;
			end
			if (cmd_valid && cmd_ready) begin
				vld_q[rd_q] <= 1'b0;
				rd_q <= !rd_q;
			end
		end
	end
endmodule

// File: rtl/wsab_div.sv
// Restoring divider, one quotient bit per cycle, clamped to 16 bits.
// Then maps the ratio to a gamma byte by binary search over k^22 <= q^10 * 2^16.
// Depends on wsab_pkg.
module wsab_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [wsab_pkg::SumW-1:0]  s,
	input  logic signed [wsab_pkg::WSumW-1:0] w,
	output logic                              done,
	output logic [7:0]                        byte_out
);
	// Both powers live in 192-bit registers and are multiplied one 32-bit limb per
	// cycle through a 32 by 16 multiplier. The register rotates right by one limb
	// each cycle, so a pass over the six limbs is one full multiply, back in order.
	localparam logic [2:0] LimbLast = 3'd5;
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV  = 4'b0010,
		S_GAM  = 4'b0100,
		S_DONE = 4'b1000
	} st_t;
	st_t                            st_q;
	logic [wsab_pkg::SumW-1:0]      rem_q;
	logic [wsab_pkg::SumW-1:0]      num_q;
	logic [wsab_pkg::WSumW-1:0]     den_q;
	logic [16:0]                    quo_q;
	logic [5:0]                     cnt_q;
	logic                           zero_q;
	logic [wsab_pkg::SumW-1:0]      rem_sh;
	logic [wsab_pkg::SumW:0]        diff;
	logic [15:0]                    qc;
	// Gamma search state: lo/hi and a power evaluator.
	logic [7:0]                     lo_q, hi_q, mid_q;
	logic [4:0]                     pc_q;
	logic [191:0]                   lp_q, rp_q;
	logic [2:0]                     lc_q;
	logic [15:0]                    cy_q;
	logic [31:0]                    mul_a;
	logic [15:0]                    mul_b;
	logic [47:0]                    prod;
	logic [1:0]                     gph_q;
	logic [8:0]                     mid_sum;

	assign rem_sh = {rem_q[wsab_pkg::SumW-2:0], num_q[wsab_pkg::SumW-1]};
	assign diff = {1'b0, rem_sh} - {17'b0, den_q};
	assign qc = quo_q[16] ? 16'hFFFF : quo_q[15:0];
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + 9'd1;
	assign mul_a = (gph_q == 2'd1) ? lp_q[31:0] : rp_q[31:0];
	assign mul_b = (gph_q == 2'd1) ? {8'b0, mid_q} : qc;
	assign prod = {16'b0, mul_a} * {32'b0, mul_b} + {32'b0, cy_q};
	assign done = (st_q == S_DONE);
	assign byte_out = lo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_q <= '0;
			pc_q <= '0;
			gph_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			mid_q <= '0;
			quo_q <= '0;
			zero_q <= 1'b0;
			rem_q <= '0;
			num_q <= '0;
			den_q <= '0;
			lp_q <= '0;
			rp_q <= '0;
			lc_q <= '0;
			cy_q <= '0;
		end else begin
			case (st_q)
				S_IDLE: if (start) begin
					zero_q <= (w == '0) || (s == '0)
						|| (s[wsab_pkg::SumW-1] != w[wsab_pkg::WSumW-1]);
					num_q <= s[wsab_pkg::SumW-1] ? wsab_pkg::SumW'(-s) : s;
					den_q <= w[wsab_pkg::WSumW-1] ? wsab_pkg::WSumW'(-w) : w;
					rem_q <= '0;
					quo_q <= '0;
					cnt_q <= 6'(wsab_pkg::SumW);
					st_q <= S_DIV;
				end
				S_DIV: begin
					if (zero_q) begin
						lo_q <= '0;
						st_q <= S_DONE;
					end else if (cnt_q == '0) begin
						lo_q <= '0;
						hi_q <= 8'd255;
						rp_q <= 192'd65536;
						pc_q <= 5'd10;
						gph_q <= 2'd0;
						lc_q <= '0;
						cy_q <= '0;
						st_q <= S_GAM;
					end else begin
						cnt_q <= cnt_q - 6'd1;
						num_q <= {num_q[wsab_pkg::SumW-2:0], 1'b0};
						if (!diff[wsab_pkg::SumW]) begin
							rem_q <= diff[wsab_pkg::SumW-1:0];
							quo_q <= (quo_q[16] || quo_q[15]) ? 17'h10000 : {quo_q[15:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							quo_q <= (quo_q[16] || quo_q[15]) ? 17'h10000 : {quo_q[15:0], 1'b0};
						end
					end
				end
				S_GAM: begin
					case (gph_q)
						2'd0: begin
							// Build q^10 * 2^16, one limb per cycle.
							if (pc_q != '0) begin
								rp_q <= {prod[31:0], rp_q[191:32]};
								if (lc_q == LimbLast) begin
									lc_q <= '0;
									cy_q <= '0;
									pc_q <= pc_q - 5'd1;
								end else begin
									lc_q <= lc_q + 3'd1;
									cy_q <= prod[47:32];
								end
							end else if (lo_q == hi_q) begin
								st_q <= S_DONE;
							end else begin
								mid_q <= mid_sum[8:1];
								lp_q <= 192'd1;
								pc_q <= 5'd22;
								gph_q <= 2'd1;
							end
						end
						2'd1: begin
							if (pc_q != '0) begin
								lp_q <= {prod[31:0], lp_q[191:32]};
								if (lc_q == LimbLast) begin
									lc_q <= '0;
									cy_q <= '0;
									pc_q <= pc_q - 5'd1;
								end else begin
									lc_q <= lc_q + 3'd1;
									cy_q <= prod[47:32];
								end
							end else begin
								if (lp_q <= rp_q) lo_q <= mid_q;
								else hi_q <= mid_q - 8'd1;
								gph_q <= 2'd0;
							end
						end
						default: gph_q <= 2'd0;
					endcase
				end
				S_DONE: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/wsab_back.sv
// Back part: pixel store, add read-modify-write, resolve and clear sweep.
// Depends on wsab_pkg and wsab_div.
module wsab_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  wsab_pkg::cmd_t cmd,
	output logic           valid,
	input  logic           ready,
	output logic [7:0]     out_red,
	output logic [7:0]     out_green,
	output logic [7:0]     out_blue,
	output logic [1:0]     status
);
	localparam int PW = 3 * wsab_pkg::SumW + wsab_pkg::WSumW;
	typedef enum logic [6:0] {
		B_INIT = 7'b0000001,
		B_IDLE = 7'b0000010,
		B_RD   = 7'b0000100,
		B_MUL  = 7'b0001000,
		B_WR   = 7'b0010000,
		B_RES  = 7'b0100000,
		B_OUT  = 7'b1000000
	} bst_t;

	logic [PW-1:0]             mem [wsab_pkg::Depth];
	logic [PW-1:0]             rd_q;
	logic [wsab_pkg::AW-1:0]   wa;
	logic [PW-1:0]             wd;
	logic                      we;
	bst_t                      st_q;
	wsab_pkg::cmd_t            c_q;
	logic [wsab_pkg::AW-1:0]   clr_q;
	logic signed [40:0]        pr_q, pg_q, pb_q;
	logic [1:0]                ch_q;
	logic                      dstart;
	logic                      ddone;
	logic [7:0]                dbyte;
	logic signed [wsab_pkg::SumW-1:0]  ds;
	logic [7:0]                r_q, g_q, b_q;
	logic                      ovld_q;
	logic [7:0]                or_q, og_q, ob_q;
	logic [1:0]                ost_q;
	logic                      sat;
	logic signed [wsab_pkg::SumW-1:0]  nr, ng, nb;
	logic signed [wsab_pkg::WSumW-1:0] nw;
	logic                      s0, s1, s2, s3;

	function automatic logic signed [wsab_pkg::SumW-1:0] sadd48(
		input logic signed [wsab_pkg::SumW-1:0] a, input logic signed [40:0] p,
		output logic o);
		logic signed [wsab_pkg::SumW:0] t;
		begin
			t = {a[wsab_pkg::SumW-1], a} + 49'(p);
			o = (t[wsab_pkg::SumW] != t[wsab_pkg::SumW-1]);
			if (!o) sadd48 = t[wsab_pkg::SumW-1:0];
			else if (t[wsab_pkg::SumW]) sadd48 = {1'b1, {(wsab_pkg::SumW-1){1'b0}}};
			else sadd48 = {1'b0, {(wsab_pkg::SumW-1){1'b1}}};
		end
	endfunction

	always_comb begin
		logic signed [wsab_pkg::WSumW:0] tw;
		nr = sadd48(rd_q[PW-1 -: wsab_pkg::SumW], pr_q, s0);
		ng = sadd48(rd_q[PW-1-wsab_pkg::SumW -: wsab_pkg::SumW], pg_q, s1);
		nb = sadd48(rd_q[PW-1-2*wsab_pkg::SumW -: wsab_pkg::SumW], pb_q, s2);
		tw = {rd_q[wsab_pkg::WSumW-1], rd_q[wsab_pkg::WSumW-1:0]} + 33'(c_q.w);
		s3 = (tw[wsab_pkg::WSumW] != tw[wsab_pkg::WSumW-1]);
		if (!s3) nw = tw[wsab_pkg::WSumW-1:0];
		else if (tw[wsab_pkg::WSumW]) nw = {1'b1, {(wsab_pkg::WSumW-1){1'b0}}};
		else nw = {1'b0, {(wsab_pkg::WSumW-1){1'b1}}};
		sat = s0 || s1 || s2 || s3;
	end

	assign we = (st_q == B_INIT) || (st_q == B_WR);
	assign wa = (st_q == B_INIT) ? clr_q : c_q.addr;
	assign wd = (st_q == B_INIT) ? '0 : {nr, ng, nb, nw};

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[c_q.addr];
	end

	always_comb begin
		case (ch_q)
			2'd0: ds = rd_q[PW-1 -: wsab_pkg::SumW];
			2'd1: ds = rd_q[PW-1-wsab_pkg::SumW -: wsab_pkg::SumW];
			default: ds = rd_q[PW-1-2*wsab_pkg::SumW -: wsab_pkg::SumW];
		endcase
	end
	assign dstart = (st_q == B_RES) && !ddone;

	wsab_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dstart),
		.s        (ds),
		.w        (rd_q[wsab_pkg::WSumW-1:0]),
		.done     (ddone),
		.byte_out (dbyte)
	);

	assign cmd_ready = (st_q == B_IDLE) && !ovld_q;
	assign valid = ovld_q;
	assign out_red = or_q;
	assign out_green = og_q;
	assign out_blue = ob_q;
	assign status = ost_q;

	always_ff @(posedge clk) begin
		if (st_q == B_MUL || st_q == B_RD) begin
			pr_q <= c_q.bad ? '0 : 41'(c_q.r) * 41'(c_q.w);
			pg_q <= c_q.bad ? '0 : 41'(c_q.g) * 41'(c_q.w);
			pb_q <= c_q.bad ? '0 : 41'(c_q.b) * 41'(c_q.w);
		end
		if (cmd_valid && cmd_ready) c_q <= cmd;
		if (ddone) begin
			if (ch_q == 2'd0) r_q <= dbyte;
			if (ch_q == 2'd1) g_q <= dbyte;
			if (ch_q == 2'd2) b_q <= dbyte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_INIT;
			clr_q <= '0;
			ch_q <= '0;
			ovld_q <= 1'b0;
			or_q <= '0;
			og_q <= '0;
			ob_q <= '0;
			ost_q <= '0;
		end else begin
			if (ovld_q && ready) ovld_q <= 1'b0;
			case (st_q)
				B_INIT: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) st_q <= B_IDLE;
				end
				B_IDLE: if (cmd_valid && cmd_ready) begin
					case (cmd.op)
						wsab_pkg::OP_ADD: st_q <= B_RD;
						wsab_pkg::OP_RESOLVE: st_q <= B_RD;
						wsab_pkg::OP_CLEAR: begin
							clr_q <= '0;
							st_q <= B_INIT;
							ovld_q <= 1'b1;
							{or_q, og_q, ob_q} <= '0;
							ost_q <= wsab_pkg::StOk;
						end
						default: begin
							ovld_q <= 1'b1;
							{or_q, og_q, ob_q} <= '0;
							ost_q <= cmd.status;
						end
					endcase
				end
				B_RD: st_q <= B_MUL;
				B_MUL: begin
					ch_q <= '0;
					st_q <= (c_q.op == wsab_pkg::OP_ADD) ? B_WR : B_RES;
				end
				B_WR: begin
					ovld_q <= 1'b1;
					{or_q, og_q, ob_q} <= '0;
					ost_q <= sat ? wsab_pkg::StSat
						: (c_q.bad ? wsab_pkg::StInvalid : wsab_pkg::StOk);
					st_q <= B_IDLE;
				end
				B_RES: if (ddone) begin
					if (ch_q == 2'd2) st_q <= B_OUT;
					else ch_q <= ch_q + 2'd1;
				end
				B_OUT: if (!ovld_q) begin
					ovld_q <= 1'b1;
					or_q <= r_q;
					og_q <= g_q;
					ob_q <= b_q;
					ost_q <= wsab_pkg::StOk;
					st_q <= B_IDLE;
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/weighted_sample_accumulation_buffer_top.sv
// Top level of the weighted sample accumulation buffer.
// Depends on wsab_pkg, wsab_front, wsab_back.
//
// Channel   Signals                                         Role
// in        valid/ready, action..sample_bad                 request in
// out       out_valid/out_ready, out_red..status            result out
// cfg       psel penable pwrite paddr pwdata prdata pready  APB registers
//
// An add gives its result after queue, store read, product and write back, in that order.
// Out-of-range and unused requests answer in the cycle after they leave the queue.
// A resolve runs three channel passes, each a 48-step divide, then an
// eight-step gamma search whose k^22 takes 22 multiplies over six limbs each.
// After reset and after a clear, a sweep over all 16384 store words zeroes the store.
// A two-entry queue lets requests in while the back part is busy or a result is stalled.
module weighted_sample_accumulation_buffer_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              valid,
	output logic                              ready,
	input  logic [1:0]                        action,
	input  logic [wsab_pkg::XW-1:0]           pos_x,
	input  logic [wsab_pkg::YW-1:0]           pos_y,
	input  logic signed [wsab_pkg::SampW-1:0] sample_red,
	input  logic signed [wsab_pkg::SampW-1:0] sample_green,
	input  logic signed [wsab_pkg::SampW-1:0] sample_blue,
	input  logic signed [wsab_pkg::WtW-1:0]   sample_weight,
	input  logic                              sample_bad,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [7:0]                        out_red,
	output logic [7:0]                        out_green,
	output logic [7:0]                        out_blue,
	output logic [1:0]                        status,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [2:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);
	localparam logic RegWidth  = 1'b0;
	localparam logic RegHeight = 1'b1;
	logic [7:0]     fw_q, fh_q;
	logic           cv, cr;
	wsab_pkg::cmd_t c;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == RegHeight) ? {24'b0, fh_q} : {24'b0, fw_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= 8'd128;
			fh_q <= 8'd128;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == RegWidth && paddr[1:0] == 2'b0) fw_q <= pwdata[7:0];
			if (paddr[2] == RegHeight && paddr[1:0] == 2'b0) fh_q <= pwdata[7:0];
		end
	end

	wsab_front u_front (
		.clk (clk), .arst_n (arst_n), .valid (valid), .ready (ready),
		.action (action), .pos_x (pos_x), .pos_y (pos_y),
		.sample_red (sample_red), .sample_green (sample_green),
		.sample_blue (sample_blue), .sample_weight (sample_weight),
		.sample_bad (sample_bad), .frame_width (fw_q), .frame_height (fh_q),
		.cmd_valid (cv), .cmd_ready (cr), .cmd (c)
	);

	wsab_back u_back (
		.clk (clk), .arst_n (arst_n), .cmd_valid (cv), .cmd_ready (cr), .cmd (c),
		.valid (out_valid), .ready (out_ready), .out_red (out_red),
		.out_green (out_green), .out_blue (out_blue), .status (status)
	);
endmodule

// File: test/weighted_sample_accumulation_buffer_top_test.sv
// Testbench for the weighted sample accumulation buffer top level.
// A scoreboard class predicts every result from its own copy of the store and registers.
// Depends on wsab_pkg and weighted_sample_accumulation_buffer_top.
`timescale 1ns / 1ps

module weighted_sample_accumulation_buffer_top_test;

	localparam int CycleLimit = 10000000;
	localparam int SweepWait  = 17000;
	localparam logic [1:0] ActUnused = 2'd3;

	typedef struct {
		logic [1:0]                        act;
		logic [wsab_pkg::XW-1:0]           x;
		logic [wsab_pkg::YW-1:0]           y;
		logic signed [wsab_pkg::SampW-1:0] r;
		logic signed [wsab_pkg::SampW-1:0] g;
		logic signed [wsab_pkg::SampW-1:0] b;
		logic signed [wsab_pkg::WtW-1:0]   w;
		logic                              bad;
	} pixel_req_t;

	typedef struct {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [1:0] st;
	} pixel_res_t;

	class accum_scoreboard;
		longint red_acc[wsab_pkg::Depth];
		longint green_acc[wsab_pkg::Depth];
		longint blue_acc[wsab_pkg::Depth];
		longint weight_acc[wsab_pkg::Depth];
		bit [191:0] pow22[256];
		int unsigned width_reg;
		int unsigned height_reg;
		pixel_res_t expected_q[$];
		int errors;

		function new();
			bit [191:0] p;
			for (int k = 0; k < 256; k++) begin
				p = 1;
				repeat (22) p = p * k;
				pow22[k] = p;
			end
			width_reg = 128;
			height_reg = 128;
			errors = 0;
			wipe();
		endfunction

		function void wipe();
			for (int i = 0; i < wsab_pkg::Depth; i++) begin
				red_acc[i] = 0;
				green_acc[i] = 0;
				blue_acc[i] = 0;
				weight_acc[i] = 0;
			end
		endfunction

		function int unsigned eff_width();
			return width_reg < wsab_pkg::MaxWidth ? width_reg : wsab_pkg::MaxWidth;
		endfunction

		function int unsigned eff_height();
			return height_reg < wsab_pkg::MaxHeight ? height_reg : wsab_pkg::MaxHeight;
		endfunction

		function longint clamp_sum(longint v, int bits, inout bit sat);
			longint hi;
			longint lo;
			hi = (longint'(1) <<< (bits - 1)) - 1;
			lo = -hi - 1;
			if (v > hi) begin
				sat = 1;
				return hi;
			end
			if (v < lo) begin
				sat = 1;
				return lo;
			end
			return v;
		endfunction

		// Largest k with k^22 <= q^10 * 2^16, the exact form of the gamma curve.
		function logic [7:0] gamma_byte(longint s, longint w);
			longint ms;
			longint mw;
			bit [191:0] q;
			bit [191:0] rhs;
			if (w == 0 || s == 0) return 0;
			if ((s < 0) != (w < 0)) return 0;
			ms = s < 0 ? -s : s;
			mw = w < 0 ? -w : w;
			q = 192'(ms / mw);
			if (q > 65535) q = 65535;
			rhs = 65536;
			repeat (10) rhs = rhs * q;
			for (int k = 255; k > 0; k--) begin
				if (pow22[k] <= rhs) return 8'(k);
			end
			return 0;
		endfunction

		function void note_request(pixel_req_t q);
			pixel_res_t res;
			int idx;
			bit sat;
			bit in_range;
			longint cr;
			longint cg;
			longint cb;
			longint cw;
			res = '{default: 0};
			sat = 0;
			in_range = q.x < eff_width() && q.y < eff_height();
			case (q.act)
				wsab_pkg::ActAdd: begin
					if (!in_range) begin
						res.st = wsab_pkg::StRange;
					end else begin
						idx = int'(q.y) * wsab_pkg::MaxWidth + int'(q.x);
						cr = q.bad ? 0 : longint'(q.r);
						cg = q.bad ? 0 : longint'(q.g);
						cb = q.bad ? 0 : longint'(q.b);
						cw = longint'(q.w);
						red_acc[idx] = clamp_sum(red_acc[idx] + cr * cw, wsab_pkg::SumW, sat);
						green_acc[idx] = clamp_sum(green_acc[idx] + cg * cw, wsab_pkg::SumW, sat);
						blue_acc[idx] = clamp_sum(blue_acc[idx] + cb * cw, wsab_pkg::SumW, sat);
						weight_acc[idx] = clamp_sum(weight_acc[idx] + cw, wsab_pkg::WSumW, sat);
						res.st = sat ? wsab_pkg::StSat
							: (q.bad ? wsab_pkg::StInvalid : wsab_pkg::StOk);
					end
				end
				wsab_pkg::ActResolve: begin
					if (!in_range) begin
						res.st = wsab_pkg::StRange;
					end else begin
						idx = (int'(eff_height()) - 1 - int'(q.y)) * wsab_pkg::MaxWidth
							+ int'(q.x);
						res.r = gamma_byte(red_acc[idx], weight_acc[idx]);
						res.g = gamma_byte(green_acc[idx], weight_acc[idx]);
						res.b = gamma_byte(blue_acc[idx], weight_acc[idx]);
					end
				end
				wsab_pkg::ActClear: wipe();
				default: ;
			endcase
			expected_q.push_back(res);
		endfunction

		function void report(string what, int got, int want);
			$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
			errors++;
		endfunction

		function void check_result(pixel_res_t got);
			pixel_res_t want;
			if (expected_q.size() == 0) begin
				report("result with no request pending", 1, 0);
				return;
			end
			want = expected_q.pop_front();
			if (got.r !== want.r) report("out_red", got.r, want.r);
			if (got.g !== want.g) report("out_green", got.g, want.g);
			if (got.b !== want.b) report("out_blue", got.b, want.b);
			if (got.st !== want.st) report("status", got.st, want.st);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic valid;
	logic ready;
	logic [1:0] action;
	logic [wsab_pkg::XW-1:0] pos_x;
	logic [wsab_pkg::YW-1:0] pos_y;
	logic signed [wsab_pkg::SampW-1:0] sample_red;
	logic signed [wsab_pkg::SampW-1:0] sample_green;
	logic signed [wsab_pkg::SampW-1:0] sample_blue;
	logic signed [wsab_pkg::WtW-1:0] sample_weight;
	logic sample_bad;
	logic out_valid;
	logic out_ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [1:0] status;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	accum_scoreboard sb;
	bit no_idle;
	bit hold_off;
	int unsigned cycles;

	weighted_sample_accumulation_buffer_top u_top (.*);

	initial clk = 0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("weighted_sample_accumulation_buffer_top_test: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result('{out_red, out_green, out_blue, status});
			if (valid && ready)
				sb.note_request('{action, pos_x, pos_y, sample_red, sample_green,
					sample_blue, sample_weight, sample_bad});
		end
	end

	// Result side: random stalls, plus one long hold-off when asked.
	initial begin
		int gap;
		out_ready = 0;
		@(posedge clk iff arst_n);
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, 9);
			if (hold_off) begin
				gap = 400;
				hold_off = 0;
			end
			if (gap > 0) begin
				out_ready <= 0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	task automatic send_request(pixel_req_t q);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			valid <= 0;
			repeat (gap) @(posedge clk);
		end
		valid <= 1;
		action <= q.act;
		pos_x <= q.x;
		pos_y <= q.y;
		sample_red <= q.r;
		sample_green <= q.g;
		sample_blue <= q.b;
		sample_weight <= q.w;
		sample_bad <= q.bad;
		do @(posedge clk); while (!(valid && ready));
	endtask

	task automatic write_reg(logic [2:0] addr, logic [31:0] data);
		valid <= 0;
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (addr == 3'd0) sb.width_reg = data[7:0];
		else sb.height_reg = data[7:0];
		@(posedge clk);
	endtask

	// The store may still be sweeping after a clear has reported, so wait it out.
	task automatic drain();
		valid <= 0;
		@(posedge clk);
		while (sb.expected_q.size() > 0) @(posedge clk);
		repeat (SweepWait) @(posedge clk);
	endtask

	task automatic set_frame(int w, int h);
		drain();
		write_reg(3'd0, w);
		write_reg(3'd4, h);
	endtask

	function automatic logic signed [wsab_pkg::SampW-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return {1'b0, {(wsab_pkg::SampW-1){1'b1}}};
			1: return {1'b1, {(wsab_pkg::SampW-1){1'b0}}};
			2: return wsab_pkg::SampW'($urandom_range(0, 65536));
			default: return wsab_pkg::SampW'($urandom);
		endcase
	endfunction

	function automatic logic signed [wsab_pkg::WtW-1:0] rand_weight();
		case ($urandom_range(0, 9))
			0: return {1'b0, {(wsab_pkg::WtW-1){1'b1}}};
			1: return {1'b1, {(wsab_pkg::WtW-1){1'b0}}};
			2: return '0;
			3, 4: return wsab_pkg::WtW'($urandom_range(1, 16384));
			default: return wsab_pkg::WtW'($urandom);
		endcase
	endfunction

	function automatic pixel_req_t rand_request(bit allow_clear);
		pixel_req_t q;
		int pick;
		int weff;
		int heff;
		weff = sb.eff_width();
		heff = sb.eff_height();
		pick = $urandom_range(0, 99);
		if (allow_clear && pick == 0) q.act = wsab_pkg::ActClear;
		else if (pick < 4) q.act = ActUnused;
		else if (pick < 64) q.act = wsab_pkg::ActAdd;
		else q.act = wsab_pkg::ActResolve;
		if (weff > 0 && heff > 0 && $urandom_range(0, 9) < 8) begin
			q.x = wsab_pkg::XW'($urandom_range(0, weff - 1));
			q.y = wsab_pkg::YW'($urandom_range(0, heff - 1));
		end else begin
			q.x = wsab_pkg::XW'($urandom);
			q.y = wsab_pkg::YW'($urandom);
		end
		q.r = rand_sample();
		q.g = rand_sample();
		q.b = rand_sample();
		q.w = rand_weight();
		q.bad = $urandom_range(0, 9) == 0;
		return q;
	endfunction

	function automatic pixel_req_t make_req(logic [1:0] act, int x, int y, int s, int w, bit bad);
		return '{act, wsab_pkg::XW'(x), wsab_pkg::YW'(y), wsab_pkg::SampW'(s),
			wsab_pkg::SampW'(s), wsab_pkg::SampW'(s), wsab_pkg::WtW'(w), bad};
	endfunction

	initial begin
		int smax;
		int smin;
		pixel_req_t q;
		sb = new();
		smax = 32'h00FFFFFF;
		smin = -32'h01000000;
		cycles = 0;
		no_idle = 0;
		hold_off = 0;
		arst_n = 0;
		valid = 0;
		action = 0;
		pos_x = 0;
		pos_y = 0;
		sample_red = 0;
		sample_green = 0;
		sample_blue = 0;
		sample_weight = 0;
		sample_bad = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		repeat (SweepWait) @(posedge clk);

		// Directed: field extremes, every action, flip, invalid sample, zero weight.
		send_request(make_req(wsab_pkg::ActResolve, 0, 0, 0, 0, 0));
		send_request(make_req(wsab_pkg::ActAdd, 0, 0, smax, 32767, 0));
		send_request(make_req(wsab_pkg::ActAdd, 127, 127, smin, -32768, 0));
		send_request(make_req(wsab_pkg::ActAdd, 5, 9, 65536, 16384, 0));
		send_request(make_req(wsab_pkg::ActAdd, 5, 9, smax, 16384, 1));
		send_request(make_req(wsab_pkg::ActAdd, 6, 9, smin, 16384, 0));
		send_request(make_req(wsab_pkg::ActAdd, 7, 9, 30000, 0, 0));
		send_request(make_req(wsab_pkg::ActResolve, 0, 127, 0, 0, 0));
		send_request(make_req(wsab_pkg::ActResolve, 127, 0, 0, 0, 0));
		send_request(make_req(wsab_pkg::ActResolve, 5, 118, 0, 0, 0));
		send_request(make_req(wsab_pkg::ActResolve, 6, 118, 0, 0, 0));
		send_request(make_req(wsab_pkg::ActResolve, 7, 118, 0, 0, 0));
		send_request(make_req(ActUnused, 127, 127, smax, -1, 1));
		send_request(make_req(wsab_pkg::ActClear, 0, 0, 0, 0, 0));
		send_request(make_req(wsab_pkg::ActResolve, 0, 127, 0, 0, 0));
		set_frame(5, 3);
		send_request(make_req(wsab_pkg::ActAdd, 5, 0, smax, 100, 0));
		send_request(make_req(wsab_pkg::ActAdd, 0, 3, smax, 100, 0));
		send_request(make_req(wsab_pkg::ActResolve, 5, 0, 0, 0, 0));
		send_request(make_req(wsab_pkg::ActAdd, 4, 2, 1000, 200, 0));
		send_request(make_req(wsab_pkg::ActResolve, 4, 0, 0, 0, 0));

		// Random over the full frame, with a long result-side hold-off in the middle.
		set_frame(128, 128);
		for (int i = 0; i < 100; i++) begin
			if (i == 40) begin
				no_idle = 1;
				hold_off = 1;
			end
			if (i == 70) no_idle = 0;
			send_request(rand_request(1));
		end

		// One pixel: pile up same-sign extremes until the color sums saturate.
		set_frame(1, 1);
		for (int i = 0; i < 270; i++) begin
			q = make_req(wsab_pkg::ActAdd, 0, 0, (i % 2) ? smax : smin,
				(i % 2) ? 32767 : -32768, (i % 37) == 5);
			if (i % 50 == 49) q.act = wsab_pkg::ActResolve;
			send_request(q);
		end
		for (int i = 0; i < 20; i++) send_request(rand_request(0));

		// Out-of-range registers: nothing fits.
		set_frame(200, 0);
		for (int i = 0; i < 20; i++) send_request(rand_request(0));

		for (int ph = 0; ph < 3; ph++) begin
			set_frame($urandom_range(1, 128), $urandom_range(1, 128));
			for (int i = 0; i < 40; i++) send_request(rand_request(ph == 1));
		end

		valid <= 0;
		@(posedge clk);
		while (sb.expected_q.size() > 0) @(posedge clk);
		repeat (500) @(posedge clk);
		if (sb.errors == 0)
			$display("weighted_sample_accumulation_buffer_top_test: clean");
		else
			$display("weighted_sample_accumulation_buffer_top_test: errors");
		$finish;
	end

endmodule

// File: sim.f
rtl/wsab_pkg.sv
rtl/wsab_front.sv
rtl/wsab_div.sv
rtl/wsab_back.sv
rtl/weighted_sample_accumulation_buffer_top.sv
test/weighted_sample_accumulation_buffer_top_test.sv
